@@ design/chtd_pkg.sv @@
// Package with shared constants of the canonical Huffman decoder.
package chtd_pkg;
  localparam int MaxSymbolsDefault  = 288;
  localparam int MaxCodeBitsDefault = 15;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpBuild  = 2'd1;
  localparam logic [1:0] OpDecode = 2'd2;

  localparam logic [2:0] StLoaded  = 3'd0;
  localparam logic [2:0] StBuilt   = 3'd1;
  localparam logic [2:0] StMore    = 3'd2;
  localparam logic [2:0] StSymbol  = 3'd3;
  localparam logic [2:0] StOversub = 3'd4;
  localparam logic [2:0] StOutside = 3'd5;

  localparam logic CfgSymbolCount = 1'b0;
  localparam logic CfgLongestBits = 1'b1;
endpackage

@@ design/canonical_huffman_tree_decoder_unit.sv @@
// Top level of the canonical Huffman table builder and bit-serial decoder.
// Items enter on in_valid_i/in_ready_o with op, symbol_index, code_length
// and stream_bit; each item gives exactly one result on out_valid_o/out_ready_i
// carrying status and decoded_symbol. The block takes one item at a time.
// A load writes the code length memory and then presents its result; a decode bit
// reads the node table memory, checks the entry and then fills the output register.
// A decode whose walk already lies outside the tree and an unknown op go straight
// to the result. A build is a sequencer over the memories: it counts lengths,
// forms next codes, assigns codes, clears the node table, inserts each symbol's
// code bit by bit and fills holes, then presents the result.
// The next item can be accepted in the cycle after the result is taken.
// Reset clears the sequencer and walk position; no clearing pass runs, and
// the code length and node memories are undefined until loaded or built.
// While the receiver stalls the result is held and no new item is taken.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) belong in idle cycles only.
module canonical_huffman_tree_decoder_unit #(
  parameter int MaxSymbols  = chtd_pkg::MaxSymbolsDefault,
  parameter int MaxCodeBits = chtd_pkg::MaxCodeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [8:0] symbol_index_i,
  input  logic [3:0] code_length_i,
  input  logic       stream_bit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [8:0] decoded_symbol_o
);
  localparam int SW = $clog2(MaxSymbols + 1);
  localparam int NW = $clog2(2 * MaxSymbols);
  localparam int EW = SW + 1;

  typedef enum logic [3:0] {
    SIdle, SLoad, SDecRd, SDecChk, SCount, SNext, SAssign, SClear,
    SInsRd, SInsChk, SFill, SOut
  } state_e;

  state_e st_q;
  logic [SW-1:0] scnt_q;
  logic [3:0] mbits_q;
  logic [8:0] sidx_q;
  logic [3:0] clen_q;
  logic       sbit_q;
  logic [2:0] status_q;
  logic [8:0] sym_q;
  logic [SW-1:0] walk_q, used_q, pos_q, n_q;
  logic [SW-1:0] s_q;
  logic [NW:0] i_q;
  logic [3:0] b_q, bitc_q;
  logic [15:0] cnt_q [16];
  logic [15:0] nxt_q [16];
  logic [3:0] len_q;
  logic [14:0] code_q;

  // Memories.
  logic [3:0]  len_mem [MaxSymbols];
  logic [14:0] code_mem [MaxSymbols];
  logic [EW-1:0] node_mem [2*MaxSymbols];
  logic        fill_mem [2*MaxSymbols];
  logic [3:0]  len_rd_q;
  logic [14:0] code_rd_q;
  logic [EW-1:0] node_rd_q;
  logic        fill_rd_q;

  // Effective register values.
  logic [SW-1:0] n_eff;
  logic [3:0]    mb_eff;
  always_comb begin
    n_eff = scnt_q;
    if (scnt_q < SW'(2)) n_eff = SW'(2);
    if (scnt_q > SW'(MaxSymbols)) n_eff = SW'(MaxSymbols);
    mb_eff = mbits_q;
    if (mbits_q == 4'd0) mb_eff = 4'd1;
    if (mbits_q > 4'(MaxCodeBits)) mb_eff = 4'(MaxCodeBits);
  end

  // Length of the last read symbol, with over-limit lengths unused.
  logic [3:0] len_use;
  assign len_use = (len_rd_q > mb_eff) ? 4'd0 : len_rd_q;

  // Shared node address and entry compare unit.
  logic [NW-1:0] naddr;
  logic [3:0] shamt;
  logic cur_bit;
  assign shamt = len_q - 4'd1 - bitc_q;
  assign cur_bit = code_q[shamt];
  always_comb begin
    case (st_q)
      SDecRd:  naddr = NW'({walk_q, sbit_q});
      SInsRd:  naddr = NW'({pos_q, cur_bit});
      default: naddr = i_q[NW-1:0];
    endcase
  end
  logic [EW-1:0] n_ext;
  logic ent_sym;
  logic [EW-1:0] ent_link;
  assign n_ext = EW'(n_q);
  assign ent_sym = node_rd_q < n_ext;
  assign ent_link = node_rd_q - n_ext;

  always_ff @(posedge clk_i) begin
    len_rd_q  <= len_mem[s_q[$clog2(MaxSymbols)-1:0]];
    code_rd_q <= code_mem[s_q[$clog2(MaxSymbols)-1:0]];
    node_rd_q <= node_mem[naddr];
    fill_rd_q <= fill_mem[naddr];
    if (st_q == SLoad && {1'b0, sidx_q} < 10'(MaxSymbols))
      len_mem[sidx_q[$clog2(MaxSymbols)-1:0]] <= clen_q;
    if (st_q == SAssign && s_q != '0)
      code_mem[s_q[$clog2(MaxSymbols)-1:0] - 1'b1] <= (len_use != 0) ?
          nxt_q[len_use][14:0] : 15'd0;
    if (st_q == SClear && i_q != '0) begin
      node_mem[i_q[NW-1:0] - 1'b1] <= '0;
      fill_mem[i_q[NW-1:0] - 1'b1] <= 1'b0;
    end
    if (st_q == SFill && i_q != '0 && !fill_rd_q) begin
      node_mem[i_q[NW-1:0] - 1'b1] <= '0;
      fill_mem[i_q[NW-1:0] - 1'b1] <= 1'b1;
    end
    if (st_q == SInsChk && !fill_rd_q) begin
      node_mem[NW'({pos_q, cur_bit})] <= (bitc_q + 4'd1 == len_q) ? EW'(s_q) :
          EW'(used_q + 1'b1) + n_ext;
      fill_mem[NW'({pos_q, cur_bit})] <= 1'b1;
    end
  end

  assign in_ready_o = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign status_o = status_q;
  assign decoded_symbol_o = sym_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      scnt_q <= SW'(288);
      mbits_q <= 4'd15;
      walk_q <= '0;
      used_q <= '0;
      status_q <= '0;
      sym_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == chtd_pkg::CfgSymbolCount) scnt_q <= SW'(cfg_wdata_i);
        else mbits_q <= cfg_wdata_i[3:0];
      end
      case (st_q)
        SIdle: begin
          if (in_valid_i) begin
            sidx_q <= symbol_index_i;
            clen_q <= code_length_i; sbit_q <= stream_bit_i;
            n_q <= n_eff;
            status_q <= chtd_pkg::StLoaded; sym_q <= '0;
            case (op_i)
              chtd_pkg::OpLoad: st_q <= SLoad;
              chtd_pkg::OpBuild: begin
                s_q <= '0; i_q <= '0;
                for (int k = 0; k < 16; k++) cnt_q[k] <= '0;
                st_q <= SCount;
              end
              chtd_pkg::OpDecode: begin
                if (walk_q >= n_eff) begin
                  walk_q <= '0; status_q <= chtd_pkg::StOutside; st_q <= SOut;
                end else st_q <= SDecRd;
              end
              default: st_q <= SOut;
            endcase
          end
        end
        SLoad: st_q <= SOut;
        SDecRd: st_q <= SDecChk;
        SDecChk: begin
          walk_q <= '0;
          if (!fill_rd_q) status_q <= chtd_pkg::StOutside;
          else if (ent_sym) begin
            status_q <= chtd_pkg::StSymbol; sym_q <= 9'(node_rd_q);
          end else if (ent_link >= n_ext) status_q <= chtd_pkg::StOutside;
          else begin
            status_q <= chtd_pkg::StMore; walk_q <= SW'(ent_link);
          end
          st_q <= SOut;
        end
        // Count lengths: the read of symbol s lands in the next cycle.
        SCount: begin
          if (i_q != '0 && len_use != 0) cnt_q[len_use] <= cnt_q[len_use] + 16'd1;
          if (s_q == n_q) begin
            b_q <= 4'd1; nxt_q[0] <= '0; st_q <= SNext;
          end else begin
            s_q <= s_q + 1'b1; i_q <= (NW+1)'(1);
          end
        end
        SNext: begin
          nxt_q[b_q] <= (b_q <= mb_eff) ?
              16'((nxt_q[b_q-4'd1] + cnt_q[b_q-4'd1]) << 1) : 16'd0;
          if (b_q == 4'd15) begin s_q <= '0; i_q <= '0; st_q <= SAssign; end
          else b_q <= b_q + 4'd1;
        end
        SAssign: begin
          if (s_q != '0 && len_use != 0) nxt_q[len_use] <= nxt_q[len_use] + 16'd1;
          if (s_q == n_q) begin i_q <= '0; st_q <= SClear; end
          else s_q <= s_q + 1'b1;
          if (s_q == '0) s_q <= SW'(1);
        end
        SClear: begin
          if (i_q == (NW+1)'({n_q, 1'b0})) begin
            i_q <= '0; s_q <= '0; pos_q <= '0; used_q <= '0; st_q <= SInsRd;
            bitc_q <= '0;
          end else i_q <= i_q + 1'b1;
        end
        // Insert codes; the length and code of s_q pass through len_rd_q and code_rd_q
        // into len_q and code_q after s_q changes, so SInsRd first waits on i_q.
        SInsRd: begin
          len_q <= len_use; code_q <= code_rd_q;
          if (s_q == n_q) begin i_q <= '0; st_q <= SFill; end
          else if (i_q < (NW+1)'(2)) i_q <= i_q + 1'b1;
          else if (len_q == 0 || bitc_q == len_q) begin
            s_q <= s_q + 1'b1; bitc_q <= '0; i_q <= '0;
          end else if (pos_q > n_q - SW'(2)) begin
            status_q <= chtd_pkg::StOversub; walk_q <= '0; st_q <= SOut;
          end else st_q <= SInsChk;
        end
        SInsChk: begin
          bitc_q <= bitc_q + 4'd1; st_q <= SInsRd;
          if (!fill_rd_q) begin
            if (bitc_q + 4'd1 == len_q) pos_q <= '0;
            else begin used_q <= used_q + 1'b1; pos_q <= used_q + 1'b1; end
          end else if (bitc_q + 4'd1 == len_q || ent_sym) begin
            status_q <= chtd_pkg::StOversub; walk_q <= '0; st_q <= SOut;
          end else pos_q <= SW'(ent_link);
        end
        SFill: begin
          if (i_q == (NW+1)'({n_q, 1'b0})) begin
            status_q <= chtd_pkg::StBuilt; walk_q <= '0; st_q <= SOut;
          end else i_q <= i_q + 1'b1;
        end
        SOut: if (out_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

@@ bench/canonical_huffman_tree_decoder_unit_tb.sv @@
// Self-checking testbench of the canonical Huffman table builder and bit-serial decoder.
module canonical_huffman_tree_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSym = 288;
  localparam logic [1:0] OpUnknown = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] op_i = '0;
  logic [8:0] symbol_index_i = '0;
  logic [3:0] code_length_i = '0;
  logic       stream_bit_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [8:0] decoded_symbol_o;

  canonical_huffman_tree_decoder_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [3:0]  lens [NSym];
  logic [15:0] codes [NSym];
  logic [9:0]  nodes [2*NSym];
  bit          filled [2*NSym];
  int unsigned walk_pos;
  logic [8:0]  cfg_count = 9'd288;
  logic [3:0]  cfg_bits = 4'd15;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] sym;
  } result_t;
  result_t pending_results[$];

  int  errors = 0;
  bit  stall_on = 1'b1;
  bit  send_gaps = 1'b1;

  function automatic int unsigned count_eff();
    if (cfg_count < 2) return 2;
    if (cfg_count > NSym) return NSym;
    return cfg_count;
  endfunction

  function automatic int unsigned bits_eff();
    return (cfg_bits < 1) ? 1 : cfg_bits;
  endfunction

  function automatic int unsigned len_of(int unsigned s, int unsigned mb);
    return (lens[s] > mb) ? 0 : lens[s];
  endfunction

  // Canonical code assignment and node table expansion.
  function automatic bit build_nodes();
    int unsigned n, mb, pos, used, len, bt, idx, v;
    int unsigned cnt [16];
    logic [15:0] nxt [16];
    bit ok, last;
    n = count_eff();
    mb = bits_eff();
    pos = 0;
    used = 0;
    ok = 1'b1;
    foreach (cnt[b]) cnt[b] = 0;
    for (int s = 0; s < n; s++) begin
      len = len_of(s, mb);
      if (len != 0) cnt[len]++;
    end
    nxt[0] = 0;
    for (int b = 1; b < 16; b++) begin
      nxt[b] = (b <= mb) ? 16'((nxt[b-1] + cnt[b-1]) << 1) : 16'd0;
    end
    for (int s = 0; s < n; s++) begin
      len = len_of(s, mb);
      if (len != 0) begin
        codes[s] = nxt[len] & 16'h7fff;
        nxt[len] = nxt[len] + 16'd1;
      end else begin
        codes[s] = 0;
      end
    end
    for (int i = 0; i < 2 * n; i++) begin
      nodes[i] = 0;
      filled[i] = 1'b0;
    end
    for (int s = 0; s < n && ok; s++) begin
      len = len_of(s, mb);
      for (int i = 0; i < len; i++) begin
        bt = (codes[s] >> (len - 1 - i)) & 1;
        last = (i + 1 == len);
        if (pos > n - 2) begin
          ok = 1'b0;
          break;
        end
        idx = 2 * pos + bt;
        if (!filled[idx]) begin
          filled[idx] = 1'b1;
          if (last) begin
            nodes[idx] = 10'(s);
            pos = 0;
          end else begin
            used++;
            nodes[idx] = 10'(used + n);
            pos = used;
          end
        end else begin
          v = nodes[idx];
          if (last || v < n) begin
            ok = 1'b0;
            break;
          end
          pos = v - n;
        end
      end
    end
    if (ok) begin
      for (int i = 0; i < 2 * n; i++) begin
        if (!filled[i]) begin
          nodes[i] = 0;
          filled[i] = 1'b1;
        end
      end
    end
    walk_pos = 0;
    return ok;
  endfunction

  function automatic result_t predict_result(logic [1:0] op, logic [8:0] si, logic [3:0] cl,
                                             logic sb);
    result_t r;
    int unsigned n, idx, v, pos;
    r = '0;
    r.status = chtd_pkg::StLoaded;
    case (op)
      chtd_pkg::OpLoad: begin
        if (si < NSym) lens[si] = cl;
      end
      chtd_pkg::OpBuild: begin
        r.status = build_nodes() ? chtd_pkg::StBuilt : chtd_pkg::StOversub;
      end
      chtd_pkg::OpDecode: begin
        n = count_eff();
        pos = walk_pos;
        walk_pos = 0;
        if (pos >= n) begin
          r.status = chtd_pkg::StOutside;
        end else begin
          idx = 2 * pos + sb;
          v = nodes[idx];
          if (!filled[idx]) begin
            r.status = chtd_pkg::StOutside;
          end else if (v < n) begin
            r.status = chtd_pkg::StSymbol;
            r.sym = 9'(v);
          end else if (v - n >= n) begin
            r.status = chtd_pkg::StOutside;
          end else begin
            r.status = chtd_pkg::StMore;
            walk_pos = v - n;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item, with an optional random gap before it.
  // Valid stays high after the last item until wait_idle drops it.
  task automatic send_item(logic [1:0] op, logic [8:0] si = 0, logic [3:0] cl = 0,
                           logic sb = 0);
    result_t exp_r;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    symbol_index_i <= si;
    code_length_i <= cl;
    stream_bit_i <= sb;
    do @(posedge clk_i); while (!in_ready_o);
    exp_r = predict_result(op, si, cl, sb);
    pending_results = {pending_results, exp_r};
    @(negedge clk_i);
  endtask

  // Receiver stalls in random bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: status %0d symbol %0d", status_o, decoded_symbol_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o);
          errors++;
        end
        if (decoded_symbol_o !== e.sym) begin
          $error("decoded_symbol: expected %0d, actual %0d", e.sym, decoded_symbol_o);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [8:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == chtd_pkg::CfgSymbolCount) cfg_count = val;
    else cfg_bits = val[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load a random length for every symbol of the alphabet.
  task automatic load_all(int unsigned maxlen, int unsigned zero_pct);
    for (int s = 0; s < NSym; s++) begin
      send_item(chtd_pkg::OpLoad, 9'(s),
                ($urandom_range(0, 99) < zero_pct) ? 4'd0 : 4'($urandom_range(1, maxlen)));
    end
  endtask

  // A complete code: pick lengths that satisfy Kraft equality for at most n symbols.
  task automatic load_complete(int unsigned n, int unsigned maxlen);
    int unsigned lv [NSym];
    int unsigned leaves, k;
    for (int s = 0; s < NSym; s++) lv[s] = 0;
    // Start from a two-symbol tree and split random leaves.
    lv[0] = 1;
    lv[1] = 1;
    leaves = 2;
    for (int t = 0; t < 40 && leaves < n; t++) begin
      k = $urandom_range(0, leaves - 1);
      if (lv[k] < maxlen) begin
        lv[k]++;
        lv[leaves] = lv[k];
        leaves++;
      end
    end
    // Shuffle positions.
    for (int s = n - 1; s > 0; s--) begin
      k = $urandom_range(0, s);
      {lv[s], lv[k]} = {lv[k], lv[s]};
    end
    for (int s = 0; s < NSym; s++) send_item(chtd_pkg::OpLoad, 9'(s), 4'(lv[s]));
  endtask

  task automatic decode_bits(int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_item(chtd_pkg::OpDecode, 0, 0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    send_item(chtd_pkg::OpLoad, 9'd300, 4'd15);
    send_item(chtd_pkg::OpLoad, 9'd511, 4'd0);
    send_item(OpUnknown, 9'h1ff, 4'hf, 1'b1);
    write_cfg(chtd_pkg::CfgSymbolCount, 9'd4);
    write_cfg(chtd_pkg::CfgLongestBits, 4'd3);
    // Lengths 2,1,3,3 form a complete code.
    send_item(chtd_pkg::OpLoad, 9'd0, 4'd2);
    send_item(chtd_pkg::OpLoad, 9'd1, 4'd1);
    send_item(chtd_pkg::OpLoad, 9'd2, 4'd3);
    send_item(chtd_pkg::OpLoad, 9'd3, 4'd3);
    send_item(chtd_pkg::OpBuild);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b0);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b1);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b1);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b1);
    // Length above the limit counts as unused; an incomplete code leaves holes.
    send_item(chtd_pkg::OpLoad, 9'd3, 4'd15);
    send_item(chtd_pkg::OpBuild);
    decode_bits(4);
    // Too many short codes oversubscribe.
    send_item(chtd_pkg::OpLoad, 9'd2, 4'd1);
    send_item(chtd_pkg::OpBuild);
    decode_bits(3);
  endtask

  task automatic test_shrink();
    send_item(chtd_pkg::OpLoad, 9'd2, 4'd3);
    send_item(chtd_pkg::OpLoad, 9'd3, 4'd3);
    send_item(chtd_pkg::OpBuild);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b1);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b1);
    // The walk now stands past a shrunken alphabet.
    write_cfg(chtd_pkg::CfgSymbolCount, 9'd2);
    send_item(chtd_pkg::OpDecode, 0, 0, 1'b0);
    decode_bits(4);
    // Register values outside the usable range are clamped.
    write_cfg(chtd_pkg::CfgSymbolCount, 9'd0);
    write_cfg(chtd_pkg::CfgLongestBits, 4'd0);
    send_item(chtd_pkg::OpBuild);
    decode_bits(4);
    write_cfg(chtd_pkg::CfgSymbolCount, 9'd511);
    write_cfg(chtd_pkg::CfgLongestBits, 4'd15);
  endtask

  task automatic test_random_trees();
    int unsigned n, mb;
    for (int r = 0; r < 4; r++) begin
      if (r == 3) begin
        stall_on = 1'b0;
        send_gaps = 1'b0;
      end
      n = (r == 2) ? 288 : $urandom_range(2, 24);
      mb = (r == 1) ? 15 : $urandom_range(1, 15);
      write_cfg(chtd_pkg::CfgSymbolCount, 9'(n));
      write_cfg(chtd_pkg::CfgLongestBits, 4'(mb));
      if (r == 3) load_all(15, 30);
      else load_complete(n, mb);
      send_item(chtd_pkg::OpBuild);
      decode_bits(25);
    end
  endtask

  initial begin
    for (int s = 0; s < NSym; s++) lens[s] = 0;
    for (int i = 0; i < 2 * NSym; i++) begin
      nodes[i] = 0;
      filled[i] = 1'b1;
    end
    walk_pos = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Every length is written before the first build.
    for (int s = 0; s < NSym; s++) send_item(chtd_pkg::OpLoad, 9'(s), 4'd0);
    test_directed();
    test_shrink();
    test_random_trees();
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

@@ sim.f @@
design/chtd_pkg.sv
design/canonical_huffman_tree_decoder_unit.sv
bench/canonical_huffman_tree_decoder_unit_tb.sv
